### design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define RWV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define RWV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rwv_pkg.sv
// Package with field widths, register indexes and control structs of the VWAP block
package rwv_pkg;

  localparam int SYM_W        = 16;
  localparam int PRICE_W      = 24;
  localparam int MID_W        = PRICE_W + 1;
  localparam int VOL_W        = 20;
  localparam int WGT_W        = MID_W + VOL_W;
  localparam int LOOKBACK_W   = 11;
  localparam int OUT_W        = 32;
  localparam int FRAC_SHIFT   = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0]  CFG_TRACKED_SYMBOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_LOOKBACK_TICKS = 2'd1;
  localparam logic [LOOKBACK_W-1:0] LOOKBACK_RST       = 11'd1024;

  typedef struct packed {
    logic capture;
    logic read_old;
    logic sub_old;
    logic add_new;
    logic div_start;
    logic div_step;
  } rwv_cmd_t;

  typedef struct packed {
    logic match;
    logic div_last;
  } rwv_status_t;

endpackage

### design/rwv_ram.sv
// Generic single-write, single-read RAM with registered read data
module rwv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rwv_datapath.sv
// Datapath: config registers, tick ring, running sums and bit-serial divider
module rwv_datapath #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rwv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rwv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rwv_pkg::SYM_W-1:0]      symbol_id_i,
  input  logic [rwv_pkg::PRICE_W-1:0]    bid_price_i,
  input  logic [rwv_pkg::PRICE_W-1:0]    ask_price_i,
  input  logic [rwv_pkg::VOL_W-1:0]      tick_volume_i,
  input  rwv_pkg::rwv_cmd_t              cmd_i,
  output rwv_pkg::rwv_status_t           status_o,
  output logic [rwv_pkg::OUT_W-1:0]      avg_price_o,
  output logic                          price_valid_o
);

  import rwv_pkg::*;

  localparam int PtrW   = $clog2(HISTORY_DEPTH);
  localparam int AddrW  = PtrW + 1;
  localparam int CntW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CmpW   = (CntW > LOOKBACK_W) ? CntW : LOOKBACK_W;
  localparam int WSumW  = WGT_W + PtrW;
  localparam int VSumW  = VOL_W + PtrW;
  localparam int DivW   = WSumW + FRAC_SHIFT;
  localparam int DCntW  = $clog2(DivW);

  logic [SYM_W-1:0]      tracked_q, tracked_d;
  logic [LOOKBACK_W-1:0] lookback_q, lookback_d;
  logic [MID_W-1:0]      mid_q, mid_d;
  logic [VOL_W-1:0]      vol_q, vol_d;
  logic                  match_q, match_d;
  logic [WGT_W-1:0]      prod_q, prod_d;
  logic                  full_q, full_d;
  logic [PtrW-1:0]       wp_q, wp_d;
  logic [CntW-1:0]       held_q, held_d;
  logic [WSumW-1:0]      wsum_q, wsum_d;
  logic [VSumW-1:0]      vsum_q, vsum_d;
  logic [DivW-1:0]       div_q, div_d;
  logic [VSumW-1:0]      rem_q, rem_d;
  logic [DCntW-1:0]      dcnt_q, dcnt_d;

  logic [CmpW-1:0]       lb_ext;
  logic [CntW-1:0]       win;
  logic [AddrW-1:0]      old_sum;
  logic [AddrW-1:0]      old_wrap;
  logic [PtrW-1:0]       old_addr;
  logic [WGT_W-1:0]      rd_wgt;
  logic [VOL_W-1:0]      rd_vol;
  logic [VSumW:0]        shifted;
  logic [VSumW:0]        trial;
  logic                  cfg_clear;

  assign lb_ext = CmpW'(lookback_q);

  always_comb begin
    priority if (lb_ext == '0) begin
      win = CntW'(1);
    end else if (lb_ext > CmpW'(HISTORY_DEPTH)) begin
      win = CntW'(HISTORY_DEPTH);
    end else begin
      win = lb_ext[CntW-1:0];
    end
  end

  assign old_sum  = AddrW'(wp_q) + AddrW'(HISTORY_DEPTH) - AddrW'(win);
  assign old_wrap = (old_sum >= AddrW'(HISTORY_DEPTH)) ?
                    old_sum - AddrW'(HISTORY_DEPTH) : old_sum;
  assign old_addr = old_wrap[PtrW-1:0];

  rwv_ram #(
    .Width(WGT_W),
    .Depth(HISTORY_DEPTH)
  ) u_wgt_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.add_new),
    .waddr_i(wp_q),
    .wdata_i(prod_q),
    .raddr_i(old_addr),
    .rdata_o(rd_wgt)
  );

  rwv_ram #(
    .Width(VOL_W),
    .Depth(HISTORY_DEPTH)
  ) u_vol_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.add_new),
    .waddr_i(wp_q),
    .wdata_i(vol_q),
    .raddr_i(old_addr),
    .rdata_o(rd_vol)
  );

  assign shifted = {rem_q, div_q[DivW-1]};
  assign trial   = shifted - {1'b0, vsum_q};

  assign cfg_clear = cfg_we_i &&
                     (cfg_index_i == CFG_TRACKED_SYMBOL || cfg_index_i == CFG_LOOKBACK_TICKS);

  always_comb begin
    tracked_d  = tracked_q;
    lookback_d = lookback_q;
    mid_d      = mid_q;
    vol_d      = vol_q;
    match_d    = match_q;
    prod_d     = prod_q;
    full_d     = full_q;
    wp_d       = wp_q;
    held_d     = held_q;
    wsum_d     = wsum_q;
    vsum_d     = vsum_q;
    div_d      = div_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;

    if (cmd_i.capture) begin
      mid_d   = MID_W'(bid_price_i) + MID_W'(ask_price_i);
      vol_d   = tick_volume_i;
      match_d = (symbol_id_i == tracked_q);
    end

    if (cmd_i.read_old) begin
      prod_d = WGT_W'(mid_q) * WGT_W'(vol_q);
      full_d = (held_q >= win);
    end

    if (cmd_i.sub_old && full_q) begin
      wsum_d = wsum_q - WSumW'(rd_wgt);
      vsum_d = vsum_q - VSumW'(rd_vol);
    end

    if (cmd_i.add_new) begin
      wsum_d = wsum_q + WSumW'(prod_q);
      vsum_d = vsum_q + VSumW'(vol_q);
      wp_d   = (wp_q == PtrW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
      held_d = full_q ? win : held_q + CntW'(1);
    end

    if (cmd_i.div_start) begin
      div_d  = {wsum_q, FRAC_SHIFT'(0)};
      rem_d  = '0;
      dcnt_d = '0;
    end

    if (cmd_i.div_step) begin
      if (!trial[VSumW]) begin
        rem_d = trial[VSumW-1:0];
        div_d = {div_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[VSumW-1:0];
        div_d = {div_q[DivW-2:0], 1'b0};
      end
      dcnt_d = dcnt_q + DCntW'(1);
    end

    if (cfg_clear) begin
      wp_d   = '0;
      held_d = '0;
      wsum_d = '0;
      vsum_d = '0;
      unique case (cfg_index_i)
        CFG_TRACKED_SYMBOL: tracked_d  = cfg_data_i[SYM_W-1:0];
        CFG_LOOKBACK_TICKS: lookback_d = cfg_data_i[LOOKBACK_W-1:0];
        default:            tracked_d  = tracked_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q  <= '0;
      lookback_q <= LOOKBACK_RST;
      match_q    <= 1'b0;
      full_q     <= 1'b0;
      wp_q       <= '0;
      held_q     <= '0;
      wsum_q     <= '0;
      vsum_q     <= '0;
      dcnt_q     <= '0;
    end else begin
      tracked_q  <= tracked_d;
      lookback_q <= lookback_d;
      match_q    <= match_d;
      full_q     <= full_d;
      wp_q       <= wp_d;
      held_q     <= held_d;
      wsum_q     <= wsum_d;
      vsum_q     <= vsum_d;
      dcnt_q     <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q  <= mid_d;
    vol_q  <= vol_d;
    prod_q <= prod_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign status_o.match    = match_q;
  assign status_o.div_last = (dcnt_q == DCntW'(DivW - 1));

  assign price_valid_o = (vsum_q != '0);
  assign avg_price_o   = price_valid_o ? div_q[OUT_W-1:0] : '0;

endmodule

### design/rwv_ctrl.sv
// Controller state machine sequencing one tick through the datapath
module rwv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_stall_i,
  input  rwv_pkg::rwv_status_t status_i,
  output rwv_pkg::rwv_cmd_t    cmd_o,
  output logic                 in_stall_o,
  output logic                 out_valid_o
);

  import rwv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_SUB   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_DINIT = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status_i.match) begin
          cmd_o.read_old = 1'b1;
          state_d        = ST_SUB;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUB: begin
        cmd_o.sub_old = 1'b1;
        state_d       = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add_new = 1'b1;
        state_d       = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

endmodule

### design/rolling_window_vwap_top.sv
// Top level of the rolling-window volume-weighted mid price block
//
// Input channel: one market tick per transfer (symbol, bid, ask, volume),
// taken when in_valid_i is high and in_stall_o is low. Ticks of another
// symbol than tracked_symbol are dropped in the look state and give no result.
// A tracked tick enters a ring of up to HISTORY_DEPTH ticks; once the window
// is full, the oldest tick is read back from the ring and taken off the sums.
// Output channel: one result per tracked tick, the mid price weighted by
// volume in 1/256-tick units, held until out_stall_i is low.
// out_valid_o rises after the look, subtract, add, divider start and divider
// step states; the restoring divider works on D = 52 + log2(HISTORY_DEPTH)
// bits (62 at the default depth) and gives one quotient bit per step.
// One tick is in work at a time; in_stall_o is high from the cycle after a
// transfer until the result is taken or the tick is dropped.
// Config writes (cfg_we_i) to either register empty the window.
// Reset empties the window and loads tracked_symbol 0 and lookback 1024.
module rolling_window_vwap_top #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rwv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rwv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rwv_pkg::SYM_W-1:0]      symbol_id_i,
  input  logic [rwv_pkg::PRICE_W-1:0]    bid_price_i,
  input  logic [rwv_pkg::PRICE_W-1:0]    ask_price_i,
  input  logic [rwv_pkg::VOL_W-1:0]      tick_volume_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rwv_pkg::OUT_W-1:0]      avg_price_o,
  output logic                           price_valid_o
);

  import rwv_pkg::*;

  rwv_cmd_t    cmd;
  rwv_status_t status;

  rwv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  rwv_datapath #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .symbol_id_i  (symbol_id_i),
    .bid_price_i  (bid_price_i),
    .ask_price_i  (ask_price_i),
    .tick_volume_i(tick_volume_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .avg_price_o  (avg_price_o),
    .price_valid_o(price_valid_o)
  );

endmodule

### design/rwv_checker.sv
// Port-level assertion checker for the VWAP block and its bind
`include "assert_macros.svh"

module rwv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_i,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic [rwv_pkg::OUT_W-1:0] avg_price_i,
  input logic                      price_valid_i
);

  `RWV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
    out_valid_i && $stable(avg_price_i) && $stable(price_valid_i),
    "stalled result changed")

  `RWV_ASSERT_IMPL(a_zero_when_invalid, clk_i, rst_ni, out_valid_i && !price_valid_i,
    avg_price_i == '0, "price nonzero with zero window volume")

  `RWV_ASSERT_IMPL(a_busy_with_result, clk_i, rst_ni, out_valid_i,
    in_stall_i, "input open while a result waits")

  `RWV_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_i,
    in_stall_i && !out_valid_i, "input open right after a transfer")

endmodule

bind rolling_window_vwap_top rwv_checker u_rwv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_i   (in_stall_o),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .avg_price_i  (avg_price_o),
  .price_valid_i(price_valid_o)
);

### tb/testbench.sv
// Self-checking testbench for the rolling-window VWAP block
`timescale 1ns / 100ps

module testbench;
  import rwv_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int LATENCY     = 6 + 52 + $clog2(DEPTH) + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

  localparam logic [SYM_W-1:0]   SYM_MAX   = {SYM_W{1'b1}};
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [VOL_W-1:0]   VOL_MAX   = {VOL_W{1'b1}};

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [PRICE_W-1:0] bid;
    logic [PRICE_W-1:0] ask;
    logic [VOL_W-1:0]   volume;
  } tick_t;

  typedef struct packed {
    logic [OUT_W-1:0] price;
    logic             valid;
  } vwap_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic  in_valid = 1'b0;
  logic  in_taken = 1'b0;
  tick_t tick_drv = '0;
  logic  out_stall = 1'b0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic [OUT_W-1:0] avg_price_o;
  logic             price_valid_o;

  tick_t tick_q[$];
  vwap_t vwap_expected[$];
  vwap_t want;

  int ticks_queued = 0;
  int ticks_accepted = 0;
  int errors = 0;
  int in_idle_pct = 12;
  int out_idle_pct = 12;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet = 0;

  logic [SYM_W-1:0] pred_symbol = '0;
  int unsigned      pred_lookback = LOOKBACK_RST;
  logic [63:0]      wgt_ring [DEPTH];
  logic [VOL_W-1:0] vol_ring [DEPTH];
  int unsigned      ring_wr = 0;
  int unsigned      ring_fill = 0;
  logic [63:0]      wgt_total = '0;
  logic [63:0]      vol_total = '0;

  rolling_window_vwap_top #(
    .HISTORY_DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .symbol_id_i  (tick_drv.symbol),
    .bid_price_i  (tick_drv.bid),
    .ask_price_i  (tick_drv.ask),
    .tick_volume_i(tick_drv.volume),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .avg_price_o  (avg_price_o),
    .price_valid_o(price_valid_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic window_clear();
    ring_wr = 0;
    ring_fill = 0;
    wgt_total = '0;
    vol_total = '0;
  endtask

  task automatic vwap_predict(input tick_t t);
    int unsigned win;
    int unsigned slot;
    int unsigned old;
    logic [63:0] wgt;
    logic [63:0] quot;
    vwap_t res;
    if (t.symbol != pred_symbol) return;
    win = (pred_lookback == 0) ? 1 : ((pred_lookback > DEPTH) ? DEPTH : pred_lookback);
    slot = ring_wr;
    if (ring_fill >= win) begin
      old = (slot + DEPTH - win) % DEPTH;
      wgt_total = wgt_total - wgt_ring[old];
      vol_total = vol_total - 64'(vol_ring[old]);
      ring_fill = win;
    end else begin
      ring_fill = ring_fill + 1;
    end
    wgt = (64'(t.bid) + 64'(t.ask)) * 64'(t.volume);
    wgt_ring[slot] = wgt;
    vol_ring[slot] = t.volume;
    wgt_total = wgt_total + wgt;
    vol_total = vol_total + 64'(t.volume);
    ring_wr = (slot + 1) % DEPTH;
    if (vol_total == 0) begin
      res.price = '0;
      res.valid = 1'b0;
    end else begin
      quot = (wgt_total << FRAC_SHIFT) / vol_total;
      res.price = quot[OUT_W-1:0];
      res.valid = 1'b1;
    end
    vwap_expected = {vwap_expected, res};
  endtask

  // call at a falling edge while the block is idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_TRACKED_SYMBOL) begin
      pred_symbol = data[SYM_W-1:0];
      window_clear();
    end else if (idx == CFG_LOOKBACK_TICKS) begin
      pred_lookback = data[LOOKBACK_W-1:0];
      window_clear();
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_tick(input logic [SYM_W-1:0] sym, input logic [PRICE_W-1:0] bid,
                            input logic [PRICE_W-1:0] ask, input logic [VOL_W-1:0] vol);
    tick_t t;
    t.symbol = sym;
    t.bid = bid;
    t.ask = ask;
    t.volume = vol;
    tick_q = {tick_q, t};
    ticks_queued++;
  endtask

  function automatic logic [PRICE_W-1:0] random_price();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return PRICE_MAX;
      default: return r[PRICE_W-1:0];
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] random_volume();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return VOL_MAX;
      2:       return VOL_W'($urandom_range(1, 15));
      default: return r[VOL_W-1:0];
    endcase
  endfunction

  // wait until every transfer is back, then let a dropped tick finish
  task automatic drain();
    while (!(ticks_accepted == ticks_queued && vwap_expected.size() == 0))
      @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n, input int tracked_pct, input bit hold);
    logic [31:0] r;
    logic [SYM_W-1:0] sym;
    if (hold) begin
      @(posedge clk_i);
      hold_requests++;
    end
    for (int k = 0; k < n; k++) begin
      r = $urandom;
      sym = ($urandom_range(99) < tracked_pct) ? pred_symbol : r[SYM_W-1:0];
      queue_tick(sym, random_price(), random_price(), random_volume());
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        tick_drv <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (vwap_expected.size() == 0) begin
        $error("unexpected transfer: avg_price %0d price_valid %0b", avg_price_o, price_valid_o);
        errors++;
      end else begin
        want = vwap_expected.pop_front();
        if (avg_price_o !== want.price) begin
          $error("avg_price: expected %0d, got %0d", want.price, avg_price_o);
          errors++;
        end
        if (price_valid_o !== want.valid) begin
          $error("price_valid: expected %0b, got %0b", want.valid, price_valid_o);
          errors++;
        end
      end
    end
    if (in_valid && !in_stall_o) begin
      ticks_accepted <= ticks_accepted + 1;
      vwap_predict(tick_drv);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset setting: symbol 0, lookback at the ring depth
    queue_tick('0, '0, '0, '0);
    queue_tick('0, PRICE_MAX, PRICE_MAX, VOL_MAX);
    queue_tick('0, '0, PRICE_MAX, 20'd1);
    queue_tick('0, PRICE_MAX, '0, 20'd1);
    queue_tick(16'd1, 24'd500, 24'd502, 20'd9);
    queue_tick(SYM_MAX, 24'd500, 24'd502, 20'd9);
    queue_tick('0, 24'd100, 24'd102, '0);
    queue_tick('0, 24'hAAAAAA, 24'h555555, 20'hAAAAA);
    queue_tick('0, 24'h555555, 24'hAAAAAA, 20'h55555);
    drain();

    cfg_write(CFG_LOOKBACK_TICKS, 16'd1);
    cfg_write(CFG_TRACKED_SYMBOL, 16'hFFFF);
    queue_tick(SYM_MAX, 24'd1000, 24'd1002, 20'd7);
    queue_tick(SYM_MAX, 24'd5, 24'd5, '0);
    queue_tick('0, 24'd77, 24'd78, 20'd3);
    queue_tick(SYM_MAX, PRICE_MAX, PRICE_MAX, VOL_MAX);
    drain();

    // upper data bits drop, leaving a lookback of zero
    cfg_write(CFG_LOOKBACK_TICKS, 16'hF800);
    cfg_write(CFG_UNMAPPED_2, 16'hFFFF);
    cfg_write(CFG_UNMAPPED_3, 16'h0000);
    queue_tick(SYM_MAX, 24'd10, 24'd20, 20'd3);
    queue_tick(SYM_MAX, 24'd10, 24'd20, '0);
    drain();

    cfg_write(CFG_LOOKBACK_TICKS, 16'd2047);
    run_phase(150, 90, 1'b0);

    cfg_write(CFG_TRACKED_SYMBOL, 16'($urandom));
    cfg_write(CFG_LOOKBACK_TICKS, 16'($urandom_range(2, 63)));
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_phase(80, 80, 1'b0);
    in_idle_pct = 12;
    out_idle_pct = 12;

    cfg_write(CFG_LOOKBACK_TICKS, 16'(DEPTH));
    run_phase(90, 85, 1'b1);

    cfg_write(CFG_LOOKBACK_TICKS, 16'(DEPTH + 1));
    run_phase(80, 85, 1'b0);

    cfg_write(CFG_UNMAPPED_2, 16'($urandom));
    cfg_write(CFG_UNMAPPED_3, 16'($urandom));
    cfg_write(CFG_LOOKBACK_TICKS, 16'd1);
    run_phase(40, 70, 1'b0);

    cfg_write(CFG_TRACKED_SYMBOL, 16'd0);
    cfg_write(CFG_LOOKBACK_TICKS, 16'($urandom_range(1, 8)));
    run_phase(60, 80, 1'b0);

    cfg_write(CFG_TRACKED_SYMBOL, 16'hFFFF);
    cfg_write(CFG_LOOKBACK_TICKS, 16'($urandom));
    run_phase(50, 75, 1'b0);

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
